FILE: design/header_sync_xor_frame_receiver_assert.svh
// Assertion macros shared by the receiver modules.
// HSXFR_ASSERT checks a property while reset is released.
`ifndef HEADER_SYNC_XOR_FRAME_RECEIVER_ASSERT_SVH
`define HEADER_SYNC_XOR_FRAME_RECEIVER_ASSERT_SVH

`define HSXFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// HSXFR_ASSERT_ALWAYS also holds during reset.
`define HSXFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/hsxfr_pkg.sv
`default_nettype none

package hsxfr_pkg;

  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 6;
  localparam int HDR_LEN       = 3;
  localparam int FRAME_LEN_DEF = 38;

  localparam logic [BYTE_W-1:0] HDR0 = 8'h55;
  localparam logic [BYTE_W-1:0] HDR1 = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR2 = 8'hDC;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // header complete or checksum good: position to first body byte, clear checksum
    logic store;    // write the accepted body word and fold it into the checksum
    logic rd_en;    // read the body buffer at the current position
    logic inc;      // advance the position
    logic ld_body;  // load the output register with the buffered body word
    logic ld_err;   // load the output register with the checksum error word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic is_hdr2;
    logic at_check;   // next input word is the checksum
    logic xor_ok;     // input word equals the running checksum
    logic last_body;  // current position is the final body byte
    logic out_free;   // output register can take a word this cycle
  } stat_t;

endpackage

`default_nettype wire

FILE: design/hsxfr_if.sv
`default_nettype none

interface hsxfr_rx_if;
  logic                          valid;
  logic                          ready;
  logic [hsxfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hsxfr_res_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [hsxfr_pkg::IDX_W-1:0]   byte_index;
  logic [hsxfr_pkg::BYTE_W-1:0]  body_byte;
  logic                          last_of_frame;

  modport source (output valid, output status, output byte_index, output body_byte,
                  output last_of_frame, input ready);
  modport sink (input valid, input status, input byte_index, input body_byte,
                input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: design/hsxfr_ctrl.sv
`default_nettype none

module hsxfr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hsxfr_pkg::stat_t stat_i,
  output hsxfr_pkg::cmd_t       cmd_o
);

  `include "header_sync_xor_frame_receiver_assert.svh"

  typedef enum logic [2:0] {
    ST_HUNT0,
    ST_HUNT1,
    ST_HUNT2,
    ST_COLLECT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_HUNT0: begin
        in_ready_o = 1'b1;
        if (accept) begin
          state_d = stat_i.is_hdr0 ? ST_HUNT1 : ST_HUNT0;
        end
      end
      ST_HUNT1: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (stat_i.is_hdr1) begin
            state_d = ST_HUNT2;
          end else begin
            state_d = stat_i.is_hdr0 ? ST_HUNT1 : ST_HUNT0;
          end
        end
      end
      ST_HUNT2: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (stat_i.is_hdr2) begin
            state_d     = ST_COLLECT;
            cmd_o.start = 1'b1;
          end else begin
            state_d = stat_i.is_hdr0 ? ST_HUNT1 : ST_HUNT0;
          end
        end
      end
      ST_COLLECT: begin
        // The checksum word waits until the output register can take a word.
        in_ready_o = !stat_i.at_check || stat_i.out_free;
        if (accept) begin
          if (!stat_i.at_check) begin
            cmd_o.store = 1'b1;
          end else if (stat_i.xor_ok) begin
            cmd_o.start = 1'b1;
            state_d     = ST_EMIT_RD;
          end else begin
            cmd_o.ld_err = 1'b1;
            state_d      = ST_HUNT0;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (stat_i.out_free) begin
          cmd_o.ld_body = 1'b1;
          if (stat_i.last_body) begin
            state_d = ST_HUNT0;
          end else begin
            cmd_o.inc = 1'b1;
            state_d   = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT0;
    end else begin
      state_q <= state_d;
    end
  end

  `HSXFR_ASSERT(a_cmd_exclusive,
    $onehot0({cmd_o.start, cmd_o.store, cmd_o.rd_en, cmd_o.ld_body, cmd_o.ld_err}),
    "controller issued conflicting datapath commands")
  `HSXFR_ASSERT(a_emit_holds,
    (state_q == ST_EMIT_LD && !stat_i.out_free) |=> (state_q == ST_EMIT_LD),
    "body word dropped while output stalled")

endmodule

`default_nettype wire

FILE: design/hsxfr_datapath.sv
`default_nettype none

module hsxfr_datapath #(
  parameter int FRAME_LEN = hsxfr_pkg::FRAME_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [hsxfr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire hsxfr_pkg::cmd_t              cmd_i,
  output hsxfr_pkg::stat_t                  stat_o,
  hsxfr_res_if.source                       res_o
);

  `include "header_sync_xor_frame_receiver_assert.svh"

  localparam int BodyLen = FRAME_LEN - 4;
  localparam int AddrW   = (BodyLen > 1) ? $clog2(BodyLen) : 1;
  localparam int IdxW    = hsxfr_pkg::IDX_W;
  localparam int ByteW   = hsxfr_pkg::BYTE_W;

  localparam logic [IdxW-1:0] FirstBody = IdxW'(hsxfr_pkg::HDR_LEN);
  localparam logic [IdxW-1:0] LastBody  = IdxW'(FRAME_LEN - 2);
  localparam logic [IdxW-1:0] CheckPos  = IdxW'(FRAME_LEN - 1);

  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [IdxW-1:0]  body_off;
  logic [AddrW-1:0] addr;
  logic [ByteW-1:0] mem_q [BodyLen];
  logic [ByteW-1:0] rdata_q;

  logic             out_valid_q, out_valid_d;
  logic             status_q;
  logic [IdxW-1:0]  index_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             out_free;

  // The frame position addresses the body buffer for both writes and reads.
  assign body_off = cnt_q - FirstBody;
  assign addr     = body_off[AddrW-1:0];
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    xor_d = xor_q;
    if (cmd_i.start) begin
      cnt_d = FirstBody;
      xor_d = '0;
    end else if (cmd_i.store) begin
      cnt_d = cnt_q + IdxW'(1);
      xor_d = xor_q ^ rx_byte_i;
    end else if (cmd_i.inc) begin
      cnt_d = cnt_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      xor_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[addr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.ld_body || cmd_i.ld_err) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_err) begin
      status_q <= 1'b1;
      index_q  <= CheckPos;
      byte_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.ld_body) begin
      status_q <= 1'b0;
      index_q  <= cnt_q;
      byte_q   <= rdata_q;
      last_q   <= (cnt_q == LastBody);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = status_q;
  assign res_o.byte_index    = index_q;
  assign res_o.body_byte     = byte_q;
  assign res_o.last_of_frame = last_q;

  assign stat_o.is_hdr0   = (rx_byte_i == hsxfr_pkg::HDR0);
  assign stat_o.is_hdr1   = (rx_byte_i == hsxfr_pkg::HDR1);
  assign stat_o.is_hdr2   = (rx_byte_i == hsxfr_pkg::HDR2);
  assign stat_o.at_check  = (cnt_q == CheckPos);
  assign stat_o.xor_ok    = (rx_byte_i == xor_q);
  assign stat_o.last_body = (cnt_q == LastBody);
  assign stat_o.out_free  = out_free;

  `HSXFR_ASSERT(a_no_overwrite,
    (cmd_i.ld_body || cmd_i.ld_err) |-> out_free,
    "output word overwritten before it was taken")
  `HSXFR_ASSERT(a_store_in_body,
    cmd_i.store |-> (cnt_q >= FirstBody && cnt_q <= LastBody),
    "body write outside the body positions")

endmodule

`default_nettype wire

FILE: design/header_sync_xor_frame_receiver.sv
`default_nettype none

// Receives one byte word per accepted handshake, hunts for the header 55 AA DC
// (overlapping starts allowed) and collects a frame of FRAME_LEN bytes whose
// final byte is the XOR of the body bytes between header and checksum. While
// hunting and collecting, a word is accepted every cycle; the checksum word is
// held off only while the output register still holds an untaken word. A good
// frame then replays its FRAME_LEN-4 body words from the single-port body
// buffer, each by a registered buffer read and then a load of the output
// register, and the next input word is taken only once the replay and any
// output stalls are done. A bad checksum produces one error word with no extra
// delay. Nothing needs clearing after reset.
module header_sync_xor_frame_receiver #(
  parameter int FRAME_LEN = hsxfr_pkg::FRAME_LEN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsxfr_rx_if.sink  rx_i,
  hsxfr_res_if.source res_o
);

  hsxfr_pkg::cmd_t  cmd;
  hsxfr_pkg::stat_t stat;

  hsxfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hsxfr_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
